@@ rtl/bfbs_pkg.sv @@
`default_nettype none

package bfbs_pkg;

   // Default frame limits; the top level takes them as parameter defaults.
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // Fixed field widths.
   localparam int CFG_W   = 9;
   localparam int PIXEL_W = 24;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 2 * CFG_W + 1;
   localparam int ROWB_W  = CFG_W + 2;
   localparam int DSZ_W   = 20;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 1'd1;

   // Input word kinds.
   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   // File layout constants.
   localparam logic [5:0]  HDR_BYTES   = 6'd54;
   localparam logic [7:0]  TAG_B       = 8'h42;
   localparam logic [7:0]  TAG_M       = 8'h4D;
   localparam logic [31:0] DATA_OFFSET = 32'h36;
   localparam logic [31:0] INFO_SIZE   = 32'h28;
   localparam logic [31:0] PLANES_BPP  = 32'h0018_0001;
   localparam logic [31:0] PELS_PER_M  = 32'h0000_2E23;

   // Header word slots after the tag.
   localparam logic [3:0] HW_FILE_SIZE = 4'd0;
   localparam logic [3:0] HW_OFFSET    = 4'd2;
   localparam logic [3:0] HW_INFO_SIZE = 4'd3;
   localparam logic [3:0] HW_WIDTH     = 4'd4;
   localparam logic [3:0] HW_HEIGHT    = 4'd5;
   localparam logic [3:0] HW_PLANES    = 4'd6;
   localparam logic [3:0] HW_DATA_SIZE = 4'd8;
   localparam logic [3:0] HW_XPPM      = 4'd9;
   localparam logic [3:0] HW_YPPM      = 4'd10;

   // What the sequencer hands to the pending stage for one output byte.
   typedef struct packed {
      logic              is_pixel;
      logic              zero;
      logic [1:0]        sel;
      logic [BYTE_W-1:0] data;
      logic              last;
   } issue_type;

   // One byte of the 54-byte header.
   function automatic logic [BYTE_W-1:0] hdr_byte(
      input logic [5:0]       hp,
      input logic [CFG_W-1:0] w,
      input logic [CFG_W-1:0] h,
      input logic [DSZ_W-1:0] dsz
   );
      logic [5:0]        off;
      logic [3:0]        k;
      logic [1:0]        b;
      logic [31:0]       word;
      logic [BYTE_W-1:0] res;
      off = hp - 6'd2;
      k   = off[5:2];
      b   = off[1:0];
      case (k) inside
         HW_FILE_SIZE:      word = 32'(dsz) + 32'(HDR_BYTES);
         HW_OFFSET:         word = DATA_OFFSET;
         HW_INFO_SIZE:      word = INFO_SIZE;
         HW_WIDTH:          word = 32'(w);
         HW_HEIGHT:         word = 32'(h);
         HW_PLANES:         word = PLANES_BPP;
         HW_DATA_SIZE:      word = 32'(dsz);
         HW_XPPM, HW_YPPM:  word = PELS_PER_M;
         default:           word = 32'd0;
      endcase
      res = word[{b, 3'b000} +: BYTE_W];
      if (hp == 6'd0) begin
         res = TAG_B;
      end else if (hp == 6'd1) begin
         res = TAG_M;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bfbs_ram.sv @@
`default_nettype none

module bfbs_ram #(
   parameter  int WIDTH = 24,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/bfbs_ctrl.sv @@
`default_nettype none

module bfbs_ctrl #(
   parameter  int MAX_WIDTH  = bfbs_pkg::MAX_WIDTH_DEF,
   parameter  int MAX_HEIGHT = bfbs_pkg::MAX_HEIGHT_DEF,
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_accept,
   input  wire logic                      req_kind,
   input  wire logic [bfbs_pkg::CFG_W-1:0] cfg_width,
   input  wire logic [bfbs_pkg::CFG_W-1:0] cfg_height,
   output logic                           ram_wr_en,
   output logic      [AW-1:0]             ram_wr_addr,
   output logic                           ram_rd_en,
   output logic      [AW-1:0]             ram_rd_addr,
   output bfbs_pkg::issue_type            issue
);

   import bfbs_pkg::*;

   localparam int LC_W = $clog2(DEPTH + 1);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PIXEL  = 2'd1;
   localparam logic [1:0] PH_PAD    = 2'd2;

   logic [LC_W-1:0]  load_count_ff, load_count_in;
   logic [1:0]       phase_ff, phase_in;
   logic [5:0]       hpos_ff, hpos_in;
   logic [CFG_W-1:0] row_ff, row_in;
   logic [CFG_W-1:0] col_ff, col_in;
   logic [1:0]       bip_ff, bip_in;

   logic [CFG_W-1:0]   eff_w, eff_h;
   logic [1:0]         pad;
   logic [2*CFG_W-1:0] frame_px;
   logic [ROWB_W-1:0]  row_bytes;
   logic [DSZ_W-1:0]   data_size;
   logic [IDX_W-1:0]   idx;
   logic               load_ok;
   logic               is_req;
   logic               do_end;
   logic [CFG_W:0]     col_next;
   logic [2:0]         bip_next;
   logic [6:0]         hpos_next;

   // Clamp the registers into the supported frame size.
   always_comb begin
      if (cfg_width == '0) begin
         eff_w = CFG_W'(1);
      end else if (32'(cfg_width) > MAX_WIDTH) begin
         eff_w = CFG_W'(MAX_WIDTH);
      end else begin
         eff_w = cfg_width;
      end
      if (cfg_height == '0) begin
         eff_h = CFG_W'(1);
      end else if (32'(cfg_height) > MAX_HEIGHT) begin
         eff_h = CFG_W'(MAX_HEIGHT);
      end else begin
         eff_h = cfg_height;
      end
   end

   // Frame sizes: padding per row, pixel count and pixel data bytes.
   assign pad       = eff_w[1:0];
   assign frame_px  = (2*CFG_W)'(eff_w) * (2*CFG_W)'(eff_h);
   assign row_bytes = {1'b0, eff_w, 1'b0} + {2'b00, eff_w} + ROWB_W'(pad);
   assign data_size = DSZ_W'(row_bytes) * DSZ_W'(eff_h);

   // Store index of the pixel being sent, rows from the bottom up.
   assign idx = IDX_W'(row_ff) * IDX_W'(eff_w) + IDX_W'(col_ff);

   assign load_ok = (32'(load_count_ff) < 32'(frame_px)) && (32'(load_count_ff) < DEPTH);
   assign is_req  = req_accept && (req_kind == KIND_REQUEST);

   // Store ports: loads write at the fill count, pixel bytes read the store.
   assign ram_wr_en   = req_accept && (req_kind == KIND_LOAD) && load_ok;
   assign ram_wr_addr = AW'(load_count_ff);
   assign ram_rd_en   = is_req && (phase_ff == PH_PIXEL);
   assign ram_rd_addr = AW'(idx);

   // Byte sequencer: header, then pixel and padding bytes row by row.
   always_comb begin
      load_count_in = load_count_ff;
      phase_in      = phase_ff;
      hpos_in       = hpos_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      bip_in        = bip_ff;
      do_end        = 1'b0;
      col_next      = {1'b0, col_ff} + 1'b1;
      bip_next      = {1'b0, bip_ff} + 1'b1;
      hpos_next     = {1'b0, hpos_ff} + 1'b1;
      issue.is_pixel = 1'b0;
      issue.zero     = (32'(idx) >= DEPTH);
      issue.sel      = bip_ff;
      issue.data     = '0;
      issue.last     = 1'b0;

      if (ram_wr_en) begin
         load_count_in = load_count_ff + 1'b1;
      end

      if (is_req) begin
         case (phase_ff)
            PH_PIXEL: begin
               issue.is_pixel = 1'b1;
               if (bip_ff >= 2'd2) begin
                  bip_in = 2'd0;
                  if (col_next >= {1'b0, eff_w}) begin
                     col_in = '0;
                     if (pad != 2'd0) begin
                        phase_in = PH_PAD;
                     end else begin
                        do_end = 1'b1;
                     end
                  end else begin
                     col_in = col_next[CFG_W-1:0];
                  end
               end else begin
                  bip_in = bip_next[1:0];
               end
            end
            PH_PAD: begin
               bip_in = bip_next[1:0];
               if (bip_next >= {1'b0, pad}) begin
                  do_end = 1'b1;
               end
            end
            default: begin
               issue.data = hdr_byte(hpos_ff, eff_w, eff_h, data_size);
               hpos_in    = hpos_next[5:0];
               if (hpos_next >= {1'b0, HDR_BYTES}) begin
                  hpos_in  = '0;
                  phase_in = PH_PIXEL;
                  row_in   = eff_h - 1'b1;
                  col_in   = '0;
                  bip_in   = 2'd0;
               end
            end
         endcase

         // End of a row: step up one row, or close the file after the top row.
         if (do_end) begin
            col_in = '0;
            bip_in = 2'd0;
            if (row_ff == '0) begin
               phase_in      = PH_HEADER;
               hpos_in       = '0;
               row_in        = '0;
               load_count_in = '0;
               issue.last    = 1'b1;
            end else begin
               row_in   = row_ff - 1'b1;
               phase_in = PH_PIXEL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         phase_ff      <= PH_HEADER;
         hpos_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         bip_ff        <= '0;
      end else begin
         load_count_ff <= load_count_in;
         phase_ff      <= phase_in;
         hpos_ff       <= hpos_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         bip_ff        <= bip_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bmp_frame_byte_serializer.sv @@
`default_nettype none

// Writes a loaded frame out as a 24-bit BMP file, one byte per request word.
// req channel: tuser is the word kind (0 loads the pixel in tdata, 1 asks for
// the next file byte); pixels are loaded in raster order, top row first.
// rsp channel: tdata is the file byte, tlast marks the final byte of the file.
// csr port: csr_we writes csr_wdata to register csr_index (0 width, 1 height).
// A request word is captured in the pending stage, then in the output register
// that drives rsp; load words give no rsp word.
// Throughput: one word per cycle on req while rsp keeps up; the pixel store
// is a single-read-port RAM read once per pixel byte.
// After the final byte the fill count and the byte sequencer go back to the
// start, so the next frame can be loaded.
// Reset clears the sequencer, the fill count and both pipeline stages and sets
// width and height to 1; pixel store contents are unknown until loaded.
// When rsp stalls, the held byte stays put, one more request can enter the
// pending stage, and then req_tready drops until rsp takes the held word.

module bmp_frame_byte_serializer #(
   parameter int MAX_WIDTH  = bfbs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bfbs_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [bfbs_pkg::PIXEL_W-1:0]  req_tdata,  // pixel_value
   input  wire logic                          req_tuser,  // kind
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [bfbs_pkg::BYTE_W-1:0]   rsp_tdata,  // out_byte
   output logic                               rsp_tlast,  // last_byte
   input  wire logic                          csr_we,
   input  wire logic [bfbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bfbs_pkg::CFG_W-1:0]    csr_wdata
);

   import bfbs_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   logic              s1_valid_ff, s1_valid_in;
   issue_type         s1_info_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;

   logic              accept;
   logic              s1_adv;
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [PIXEL_W-1:0] ram_rd_data;
   issue_type         issue;
   logic [BYTE_W-1:0] s1_byte;

   // Configuration registers.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:  width_in  = csr_wdata;
            REG_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(1);
         height_ff <= CFG_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Handshake: the pending stage frees up whenever it can move to the output.
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   bfbs_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (accept),
      .req_kind    (req_tuser),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .issue       (issue)
   );

   bfbs_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Pick the byte of the stored pixel (blue, green, red) or the fixed byte.
   always_comb begin
      s1_byte = s1_info_ff.data;
      if (s1_info_ff.is_pixel) begin
         case (s1_info_ff.sel)
            2'd0:    s1_byte = ram_rd_data[7:0];
            2'd1:    s1_byte = ram_rd_data[15:8];
            2'd2:    s1_byte = ram_rd_data[23:16];
            default: s1_byte = '0;
         endcase
         if (s1_info_ff.zero) begin
            s1_byte = '0;
         end
      end
   end

   // Valid bits of the pending stage and the output register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept && (req_tuser == KIND_REQUEST)) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == KIND_REQUEST)) begin
         s1_info_ff <= issue;
      end
      if (s1_adv) begin
         out_byte_ff <= s1_byte;
         out_last_ff <= s1_info_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/bfbs_checker.sv @@
`default_nettype none

module bfbs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [bfbs_pkg::PIXEL_W-1:0]  req_tdata,
   input wire logic                          req_tuser,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [bfbs_pkg::BYTE_W-1:0]   rsp_tdata,
   input wire logic                          rsp_tlast,
   input wire logic                          csr_we,
   input wire logic [bfbs_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [bfbs_pkg::CFG_W-1:0]    csr_wdata
);

   // A held output word keeps its byte and its last flag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // A new output word comes from an accepted request word via the pending stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser, 2))
      else $error("rsp word without a request word");

   // Input back-pressure only comes from a stalled output word.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without rsp stall");

endmodule

bind bmp_frame_byte_serializer bfbs_checker u_bfbs_checker (.*);

`default_nettype wire
